// ----- hdl/wgs_pkg.sv -----
// Shared constants, types and helpers for the weighted graph store.
`timescale 1ns / 1ps
package wgs_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int WEIGHT_BITS  = 32;
   localparam int VERT_BITS    = $clog2(MAX_VERTICES);
   localparam int VCNT_BITS    = VERT_BITS + 1;
   localparam int PAIR_SLOTS   = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
   localparam int SLOT_BITS    = $clog2(PAIR_SLOTS);
   localparam int CNT_BITS     = 7;
   localparam int TREE_DEPTH   = MAX_VERTICES - 1;
   localparam int TREE_BITS    = $clog2(TREE_DEPTH + 1);
   localparam logic [VCNT_BITS-1:0] VCNT_RESET = VCNT_BITS'(MAX_VERTICES);

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_SET    = 3'd1,
      OP_REMOVE = 3'd2,
      OP_GET    = 3'd3,
      OP_DEGREE = 3'd4,
      OP_PATH   = 3'd5,
      OP_CONN   = 3'd6,
      OP_TREE   = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE, S_RMW, S_DEG, S_DEG_END, S_INIT, S_SCAN, S_SCAN_END, S_DECIDE,
      S_MERGE, S_MERGE_END, S_PATH_RD, S_PATH_CMP, S_EMIT
   } state_type;

   typedef struct packed {
      logic                   clear;
      logic                   wr_en;
      logic                   wr_valid;
      logic [SLOT_BITS-1:0]   addr;
      logic [WEIGHT_BITS-1:0] wr_data;
   } edge_req_type;

   typedef struct packed {
      logic [VERT_BITS-1:0] rd_addr_a;
      logic [VERT_BITS-1:0] rd_addr_b;
      logic                 wr_en;
      logic [VERT_BITS-1:0] wr_addr;
      logic [VERT_BITS-1:0] wr_data;
   } label_req_type;

   // Triangular slot of an unordered vertex pair.
   function automatic logic [SLOT_BITS-1:0] slot_of(input logic [VERT_BITS-1:0] x,
                                                    input logic [VERT_BITS-1:0] y);
      int lo;
      int hi;
      int s;
      lo = (x < y) ? int'(x) : int'(y);
      hi = (x < y) ? int'(y) : int'(x);
      s  = lo * MAX_VERTICES + hi - (((lo + 1) * (lo + 2)) >> 1);
      return SLOT_BITS'(s);
   endfunction

   function automatic logic is_pos(input logic [WEIGHT_BITS-1:0] w);
      return (w != '0) && !w[WEIGHT_BITS-1];
   endfunction

endpackage

// ----- hdl/weighted_graph_store_with_mst.sv -----
// Top level: command sequencer of the weighted graph store with spanning tree.
`timescale 1ns / 1ps
// Undirected weighted graph of up to 16 vertices held in a 120-entry weight
// memory. Clear and refused commands answer in the cycle after start; set,
// remove and get read the entry, then set, and remove of a present edge,
// write it back; degree reads the slots of vertex a. Path, connectivity and
// spanning tree share one union-find sequencer: a label init of all 16
// vertices, then up to n-1 rounds, each a scan of the n(n-1)/2 pairs through
// the weight memory port plus a relabel sweep over the n vertices. The
// spanning tree then comes out as back-to-back result items, lightest first,
// rsp_last on the final one. Results are strobed by rsp_valid for exactly one
// cycle and cannot be stalled. Writing csr_vertex_count clears the graph.
module weighted_graph_store_with_mst
   import wgs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [2:0]             req_operation,
   input  logic [VCNT_BITS-1:0]   req_vertex_a,
   input  logic [VCNT_BITS-1:0]   req_vertex_b,
   input  logic signed [31:0]     req_edge_weight,
   output logic                   rsp_valid,
   output logic                   rsp_status,
   output logic signed [31:0]     rsp_out_weight,
   output logic [CNT_BITS-1:0]    rsp_count,
   output logic [VERT_BITS-1:0]   rsp_end_a,
   output logic [VERT_BITS-1:0]   rsp_end_b,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [VCNT_BITS-1:0]   csr_vertex_count
);

   state_type state_ff, state_in;
   op_type    op_ff, op_in, req_op;

   logic [VCNT_BITS-1:0]   vcnt_ff, vcnt_in;
   logic [VCNT_BITS-1:0]   a_ff, a_in, b_ff, b_in;
   logic [WEIGHT_BITS-1:0] w_ff, w_in;
   logic [CNT_BITS-1:0]    total_ff, total_in;
   logic [VCNT_BITS-1:0]   pi_ff, pi_in, pj_ff, pj_in, cnt_ff, cnt_in;
   logic [VCNT_BITS-1:0]   comps_ff, comps_in, deg_ff, deg_in;
   logic                   pv_ff, pv_in;
   logic [VERT_BITS-1:0]   pa_ff, pa_in, pb_ff, pb_in;
   logic                   bf_ff, bf_in;
   logic [WEIGHT_BITS-1:0] bw_ff, bw_in;
   logic [VERT_BITS-1:0]   ba_ff, ba_in, bb_ff, bb_in, bla_ff, bla_in, blb_ff, blb_in;
   logic [WEIGHT_BITS-1:0] tw_ff [TREE_DEPTH];
   logic [VERT_BITS-1:0]   ta_ff [TREE_DEPTH];
   logic [VERT_BITS-1:0]   tb_ff [TREE_DEPTH];
   logic [TREE_BITS-1:0]   tcnt_ff, tcnt_in;
   logic                   tree_we;

   logic                   rv_ff, rv_in, rs_ff, rs_in, rl_ff, rl_in;
   logic [WEIGHT_BITS-1:0] rw_ff, rw_in;
   logic [CNT_BITS-1:0]    rc_ff, rc_in;
   logic [VERT_BITS-1:0]   rea_ff, rea_in, reb_ff, reb_in;

   edge_req_type           ereq;
   label_req_type          lreq;
   logic [WEIGHT_BITS-1:0] ed;
   logic [VERT_BITS-1:0]   lab_a, lab_b;

   logic [VCNT_BITS-1:0]   n;
   logic                   accept, cfg_wr, req_pair_ok, req_a_ok, req_b_ok;
   logic                   old_pos, cand, scan_last, deg_hit, finish_conn;
   logic [TREE_BITS-1:0]   ecnt;

   wgs_edge_mem u_edge (.clock, .reset, .req(ereq), .rd_data(ed));
   wgs_label_mem u_label (.clock, .req(lreq), .rd_data_a(lab_a), .rd_data_b(lab_b));

   always_comb begin
      if (vcnt_ff < VCNT_BITS'(2)) begin
         n = VCNT_BITS'(2);
      end else if (vcnt_ff > VCNT_BITS'(MAX_VERTICES)) begin
         n = VCNT_BITS'(MAX_VERTICES);
      end else begin
         n = vcnt_ff;
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign csr_ready   = !busy;
   assign accept      = start && !busy;
   assign cfg_wr      = csr_valid && csr_ready;
   assign req_op      = op_type'(req_operation);
   assign req_a_ok    = req_vertex_a < n;
   assign req_b_ok    = req_vertex_b < n;
   assign req_pair_ok = req_a_ok && req_b_ok && (req_vertex_a != req_vertex_b);
   assign old_pos     = is_pos(ed);
   assign cand        = pv_ff && old_pos && (lab_a != lab_b) && (!bf_ff || ed < bw_ff);
   assign scan_last   = !(pj_ff + 1'b1 < n) && !(VCNT_BITS'(pi_ff + 2'd2) < n);
   assign deg_hit     = pv_ff && old_pos;
   assign finish_conn = bf_ff && (comps_ff == VCNT_BITS'(2));
   assign ecnt        = cnt_ff[TREE_BITS-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_CLEAR: state_in = S_IDLE;
                  OP_SET, OP_REMOVE, OP_GET: state_in = req_pair_ok ? S_RMW : S_IDLE;
                  OP_DEGREE: state_in = req_a_ok ? S_DEG : S_IDLE;
                  OP_PATH: state_in = (req_a_ok && req_b_ok) ? S_INIT : S_IDLE;
                  OP_CONN, OP_TREE: state_in = S_INIT;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_RMW:      state_in = S_IDLE;
         S_DEG:      state_in = (cnt_ff == n - 1'b1) ? S_DEG_END : S_DEG;
         S_DEG_END:  state_in = S_IDLE;
         S_INIT:     state_in = (cnt_ff == VCNT_BITS'(MAX_VERTICES - 1)) ? S_SCAN : S_INIT;
         S_SCAN:     state_in = scan_last ? S_SCAN_END : S_SCAN;
         S_SCAN_END: state_in = S_DECIDE;
         S_DECIDE: begin
            if (bf_ff && !finish_conn) begin
               state_in = S_MERGE;
            end else begin
               priority if (op_ff == OP_TREE && finish_conn) begin
                  state_in = S_EMIT;
               end else if (op_ff == OP_PATH && !finish_conn) begin
                  state_in = S_PATH_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_MERGE:     state_in = (cnt_ff == n - 1'b1) ? S_MERGE_END : S_MERGE;
         S_MERGE_END: state_in = S_SCAN;
         S_PATH_RD:   state_in = S_PATH_CMP;
         S_PATH_CMP:  state_in = S_IDLE;
         S_EMIT:      state_in = (TREE_BITS'(ecnt + 1'b1) == tcnt_ff) ? S_IDLE : S_EMIT;
         default:     state_in = S_IDLE;
      endcase
   end

   // Datapath and memory requests
   always_comb begin
      op_in    = op_ff;
      vcnt_in  = vcnt_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      w_in     = w_ff;
      total_in = total_ff;
      pi_in    = pi_ff;
      pj_in    = pj_ff;
      cnt_in   = cnt_ff;
      comps_in = comps_ff;
      deg_in   = deg_ff;
      pv_in    = 1'b0;
      pa_in    = pa_ff;
      pb_in    = pb_ff;
      bf_in    = bf_ff;
      bw_in    = bw_ff;
      ba_in    = ba_ff;
      bb_in    = bb_ff;
      bla_in   = bla_ff;
      blb_in   = blb_ff;
      tcnt_in  = tcnt_ff;
      tree_we  = 1'b0;
      rv_in    = 1'b0;
      rs_in    = rs_ff;
      rw_in    = rw_ff;
      rc_in    = rc_ff;
      rea_in   = '0;
      reb_in   = '0;
      rl_in    = 1'b1;

      ereq          = '0;
      ereq.addr     = slot_of(a_ff[VERT_BITS-1:0], b_ff[VERT_BITS-1:0]);
      lreq          = '0;
      lreq.rd_addr_a = pi_ff[VERT_BITS-1:0];
      lreq.rd_addr_b = pj_ff[VERT_BITS-1:0];

      if (cand && (state_ff == S_SCAN || state_ff == S_SCAN_END)) begin
         bf_in  = 1'b1;
         bw_in  = ed;
         ba_in  = pa_ff;
         bb_in  = pb_ff;
         bla_in = lab_a;
         blb_in = lab_b;
      end

      unique case (state_ff)
         S_IDLE: begin
            ereq.addr = slot_of(req_vertex_a[VERT_BITS-1:0], req_vertex_b[VERT_BITS-1:0]);
            if (cfg_wr) begin
               vcnt_in    = csr_vertex_count;
               ereq.clear = 1'b1;
               total_in   = '0;
            end
            if (accept) begin
               op_in  = req_op;
               a_in   = req_vertex_a;
               b_in   = req_vertex_b;
               w_in   = req_edge_weight[WEIGHT_BITS-1:0];
               cnt_in = '0;
               deg_in = '0;
               comps_in = n;
               tcnt_in  = '0;
               rs_in  = 1'b1;
               rw_in  = '0;
               rc_in  = total_ff;
               unique case (req_op)
                  OP_CLEAR: begin
                     ereq.clear = 1'b1;
                     total_in   = '0;
                     rv_in      = 1'b1;
                     rs_in      = 1'b0;
                     rc_in      = '0;
                  end
                  OP_SET, OP_REMOVE, OP_GET: begin
                     rv_in = !req_pair_ok;
                     if (req_op == OP_GET) begin
                        rw_in = '1;
                     end
                  end
                  OP_DEGREE: begin
                     rv_in = !req_a_ok;
                     rc_in = '0;
                  end
                  OP_PATH: rv_in = !(req_a_ok && req_b_ok);
                  OP_CONN, OP_TREE: rv_in = 1'b0;
                  default: rv_in = 1'b0;
               endcase
            end
         end
         S_RMW: begin
            rv_in = 1'b1;
            rw_in = '0;
            rs_in = 1'b0;
            unique case (op_ff)
               OP_SET: begin
                  ereq.wr_en    = 1'b1;
                  ereq.wr_valid = 1'b1;
                  ereq.wr_data  = w_ff;
                  priority if (!old_pos && is_pos(w_ff)) begin
                     total_in = total_ff + 1'b1;
                  end else if (old_pos && !is_pos(w_ff) && total_ff != '0) begin
                     total_in = total_ff - 1'b1;
                  end else begin
                     total_in = total_ff;
                  end
               end
               OP_REMOVE: begin
                  if (old_pos) begin
                     ereq.wr_en    = 1'b1;
                     ereq.wr_valid = 1'b0;
                     if (total_ff != '0) begin
                        total_in = total_ff - 1'b1;
                     end
                  end else begin
                     rs_in = 1'b1;
                  end
               end
               OP_GET: begin
                  rs_in = !old_pos;
                  rw_in = ed;
               end
               default: rs_in = 1'b1;
            endcase
            rc_in = total_in;
         end
         S_DEG, S_DEG_END: begin
            ereq.addr = slot_of(a_ff[VERT_BITS-1:0], cnt_ff[VERT_BITS-1:0]);
            pv_in  = (state_ff == S_DEG) && (cnt_ff != a_ff);
            cnt_in = cnt_ff + 1'b1;
            deg_in = deg_ff + VCNT_BITS'(deg_hit);
            if (state_ff == S_DEG_END) begin
               rv_in = 1'b1;
               rs_in = 1'b0;
               rw_in = '0;
               rc_in = CNT_BITS'(deg_in);
            end
         end
         S_INIT: begin
            lreq.wr_en   = 1'b1;
            lreq.wr_addr = cnt_ff[VERT_BITS-1:0];
            lreq.wr_data = cnt_ff[VERT_BITS-1:0];
            cnt_in = cnt_ff + 1'b1;
            pi_in  = '0;
            pj_in  = VCNT_BITS'(1);
            bf_in  = 1'b0;
         end
         S_SCAN: begin
            ereq.addr = slot_of(pi_ff[VERT_BITS-1:0], pj_ff[VERT_BITS-1:0]);
            pv_in = 1'b1;
            pa_in = pi_ff[VERT_BITS-1:0];
            pb_in = pj_ff[VERT_BITS-1:0];
            if (pj_ff + 1'b1 < n) begin
               pj_in = pj_ff + 1'b1;
            end else begin
               pi_in = pi_ff + 1'b1;
               pj_in = VCNT_BITS'(pi_ff + 2'd2);
            end
         end
         S_SCAN_END: pv_in = 1'b0;
         S_DECIDE: begin
            cnt_in = '0;
            rs_in  = 1'b1;
            rw_in  = '0;
            rc_in  = total_ff;
            if (bf_ff) begin
               comps_in = comps_ff - 1'b1;
               if (op_ff == OP_TREE) begin
                  tree_we = 1'b1;
                  tcnt_in = tcnt_ff + 1'b1;
               end
            end
            if (!bf_ff || finish_conn) begin
               unique case (op_ff)
                  OP_TREE: rv_in = !finish_conn;
                  OP_PATH: begin
                     rv_in = finish_conn;
                     rs_in = 1'b0;
                  end
                  default: begin
                     rv_in = 1'b1;
                     rs_in = !finish_conn;
                  end
               endcase
            end
         end
         S_MERGE, S_MERGE_END: begin
            lreq.rd_addr_a = cnt_ff[VERT_BITS-1:0];
            pv_in  = (state_ff == S_MERGE);
            pa_in  = cnt_ff[VERT_BITS-1:0];
            cnt_in = cnt_ff + 1'b1;
            // relabel the absorbed component
            if (pv_ff && lab_a == blb_ff) begin
               lreq.wr_en   = 1'b1;
               lreq.wr_addr = pa_ff;
               lreq.wr_data = bla_ff;
            end
            pi_in = '0;
            pj_in = VCNT_BITS'(1);
            bf_in = 1'b0;
         end
         S_PATH_RD: begin
            lreq.rd_addr_a = a_ff[VERT_BITS-1:0];
            lreq.rd_addr_b = b_ff[VERT_BITS-1:0];
         end
         S_PATH_CMP: begin
            rv_in = 1'b1;
            rs_in = (lab_a != lab_b);
            rw_in = '0;
            rc_in = total_ff;
         end
         S_EMIT: begin
            rv_in  = 1'b1;
            rs_in  = 1'b0;
            rw_in  = tw_ff[ecnt];
            rc_in  = total_ff;
            rea_in = ta_ff[ecnt];
            reb_in = tb_ff[ecnt];
            rl_in  = (TREE_BITS'(ecnt + 1'b1) == tcnt_ff);
            cnt_in = cnt_ff + 1'b1;
         end
         default: rv_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vcnt_ff  <= VCNT_RESET;
         total_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         vcnt_ff  <= vcnt_in;
         total_ff <= total_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      w_ff     <= w_in;
      pi_ff    <= pi_in;
      pj_ff    <= pj_in;
      cnt_ff   <= cnt_in;
      comps_ff <= comps_in;
      deg_ff   <= deg_in;
      pv_ff    <= pv_in;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      bf_ff    <= bf_in;
      bw_ff    <= bw_in;
      ba_ff    <= ba_in;
      bb_ff    <= bb_in;
      bla_ff   <= bla_in;
      blb_ff   <= blb_in;
      tcnt_ff  <= tcnt_in;
      rs_ff    <= rs_in;
      rw_ff    <= rw_in;
      rc_ff    <= rc_in;
      rea_ff   <= rea_in;
      reb_ff   <= reb_in;
      rl_ff    <= rl_in;
      if (tree_we) begin
         tw_ff[tcnt_ff[VERT_BITS-1:0]] <= bw_ff;
         ta_ff[tcnt_ff[VERT_BITS-1:0]] <= ba_ff;
         tb_ff[tcnt_ff[VERT_BITS-1:0]] <= bb_ff;
      end
   end

   assign rsp_valid      = rv_ff;
   assign rsp_status     = rs_ff;
   assign rsp_out_weight = 32'(signed'(rw_ff));
   assign rsp_count      = rc_ff;
   assign rsp_end_a      = rea_ff;
   assign rsp_end_b      = reb_ff;
   assign rsp_last       = rl_ff;

`ifndef SYNTHESIS
   a_tree_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("spanning tree run broken");
   a_fail_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_last)
      else $error("failure result not final");
   a_total_range: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_BITS'(PAIR_SLOTS))
      else $error("edge count out of range");
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> tcnt_ff != '0 && ecnt < tcnt_ff)
      else $error("tree emit beyond stored edges");
`endif

endmodule

// ----- hdl/wgs_edge_mem.sv -----
// Weight table memory with per-entry valid bits; an invalid entry reads as -1.
`timescale 1ns / 1ps
module wgs_edge_mem
   import wgs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  edge_req_type           req,
   output logic [WEIGHT_BITS-1:0] rd_data
);

   logic [WEIGHT_BITS-1:0] mem [PAIR_SLOTS];
   logic [PAIR_SLOTS-1:0]  vld_ff;
   logic [WEIGHT_BITS-1:0] rdata_ff;
   logic                   rvld_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.addr] <= req.wr_data;
      end
      rdata_ff <= mem[req.addr];
   end

   always_ff @(posedge clock) begin
      if (reset || req.clear) begin
         vld_ff  <= '0;
         rvld_ff <= 1'b0;
      end else begin
         rvld_ff <= vld_ff[req.addr];
         if (req.wr_en) begin
            vld_ff[req.addr] <= req.wr_valid;
         end
      end
   end

   assign rd_data = rvld_ff ? rdata_ff : '1;

endmodule

// ----- hdl/wgs_label_mem.sv -----
// Component label memory: one write port, two registered read ports.
`timescale 1ns / 1ps
module wgs_label_mem
   import wgs_pkg::*;
(
   input  logic                 clock,
   input  label_req_type        req,
   output logic [VERT_BITS-1:0] rd_data_a,
   output logic [VERT_BITS-1:0] rd_data_b
);

   logic [VERT_BITS-1:0] mem [MAX_VERTICES];
   logic [VERT_BITS-1:0] rda_ff;
   logic [VERT_BITS-1:0] rdb_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      rda_ff <= mem[req.rd_addr_a];
      rdb_ff <= mem[req.rd_addr_b];
   end

   assign rd_data_a = rda_ff;
   assign rd_data_b = rdb_ff;

endmodule
